// ===== src/ofr_pkg.sv =====
// Shared types, codes and helpers for the ordered fragment reassembler.
// No dependencies.
package ofr_pkg;

    localparam int DEF_QUEUE_DEPTH        = 64;
    localparam int DEF_MAX_FRAGMENT_BYTES = 1024;
    localparam int DEF_BUFFER_SLOTS       = 256;
    localparam int RESULT_CAP             = 64;
    localparam int RES_CNT_W              = 8;

    localparam logic OP_ARRIVE  = 1'b0;
    localparam logic OP_PROCESS = 1'b1;

    localparam logic [1:0] FK_FULL   = 2'd0;
    localparam logic [1:0] FK_FIRST  = 2'd1;
    localparam logic [1:0] FK_MIDDLE = 2'd2;
    localparam logic [1:0] FK_LAST   = 2'd3;

    localparam logic [1:0] RK_STATUS = 2'd0;
    localparam logic [1:0] RK_PACKET = 2'd1;
    localparam logic [1:0] RK_NONE   = 2'd2;

    localparam logic [1:0] ST_ACCEPTED  = 2'd0;
    localparam logic [1:0] ST_STALE     = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [15:0] id;
        logic [1:0]  kind;
        logic [7:0]  handle;
        logic [10:0] length;
    } entry_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [15:0] id;
        logic [7:0]  handle;
        logic [10:0] length;
        logic        msg_start;
        logic        msg_end;
    } result_t;

    // a newer than b across 16-bit wraparound; half-range distance only counts when a > b
    function automatic logic seq_newer(logic [15:0] a, logic [15:0] b);
        logic [15:0] d;
        begin
            d = a - b;
            seq_newer = (d != 16'd0) && ((d < 16'd32768) || ((d == 16'd32768) && (a > b)));
        end
    endfunction

endpackage

// ===== src/ordered_fragment_reassembler_core.sv =====
// Top level of the ordered fragment reassembler: descriptor queue in a circular
// memory, sequencer for ordered insert and delivery scan, registered result port.
// Depends on ofr_pkg.
//
// Usage:
//   s_* carries one transaction per request. s_tuser selects arrival (0) or process
//   request (1); s_tdata carries the descriptor. s_tready is high only while the
//   sequencer is idle, so one request is worked on at a time.
//   m_* returns results. An arrival yields one status transaction. A process
//   request yields the delivered packets in queue order, or one "nothing found"
//   transaction; m_tlast marks the final transaction of each request.
//   An arrival compares queue entries to find the insert point and moves the
//   later entries up one place before it writes the new one. A process
//   request visits queue positions in order, checks the further fragments of
//   each run and delivers the packets of each complete run. The sequencer
//   returns to idle after each request before the next is accepted.
//   A stalled receiver holds the output register; the sequencer then waits and
//   no transaction is lost. Reset empties the queue, clears the overflow flag
//   and sets the last delivered id to 65535; memory contents are not cleared.
module ordered_fragment_reassembler_core #(
    parameter int QUEUE_DEPTH        = ofr_pkg::DEF_QUEUE_DEPTH,
    parameter int MAX_FRAGMENT_BYTES = ofr_pkg::DEF_MAX_FRAGMENT_BYTES,
    parameter int BUFFER_SLOTS       = ofr_pkg::DEF_BUFFER_SLOTS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // incoming_id, incoming_kind, incoming_handle, incoming_length
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // arrival_status, out_id, out_handle, out_length,
                                   // message_start, message_end
    output logic [1:0]  m_tuser,   // result_kind
    output logic        m_tlast    // run_last
);
    import ofr_pkg::*;

    localparam int AW   = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int PHYS = 1 << AW;

    typedef enum logic [14:0] {
        S_IDLE     = 15'b000000000000001,
        A_START    = 15'b000000000000010,
        A_LASTCHK  = 15'b000000000000100,
        A_SCAN     = 15'b000000000001000,
        A_FULLCHK  = 15'b000000000010000,
        A_SHIFT    = 15'b000000000100000,
        A_INSERT   = 15'b000000001000000,
        A_RESULT   = 15'b000000010000000,
        P_START    = 15'b000000100000000,
        P_NEXT     = 15'b000001000000000,
        P_HEAD     = 15'b000010000000000,
        P_RUN      = 15'b000100000000000,
        P_EMIT_RD  = 15'b001000000000000,
        P_EMIT     = 15'b010000000000000,
        P_FINISH   = 15'b100000000000000
    } state_t;

    entry_t mem [PHYS];
    entry_t rdata_reg;

    state_t state_reg, state_next;
    entry_t in_reg, in_next;
    logic   op_reg, op_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] head_reg, head_next;
    logic [15:0]   last_id_reg, last_id_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [CW-1:0] s_reg, s_next, t_reg, t_next, pos_reg, pos_next;
    logic [CW-1:0] lastidx_reg, lastidx_next;
    logic [15:0]   expect_reg, expect_next, cand_reg, cand_next;
    logic [RES_CNT_W-1:0] n_reg, n_next;
    logic          any_reg, any_next;
    logic [1:0]    status_reg, status_next;
    result_t       hold_reg, hold_next;
    logic          hold_valid_reg, hold_valid_next;
    result_t       m_res_reg, m_res_next;
    logic          m_valid_reg, m_valid_next, m_last_reg, m_last_next;

    logic [AW-1:0] raddr, waddr;
    logic          wen;
    entry_t        wdata;
    logic          out_free;

    function automatic logic [AW-1:0] phys(logic [CW-1:0] li);
        return head_reg + li[AW-1:0];
    endfunction

    // handle modulo slot count by shifted compare and subtract
    function automatic logic [7:0] slot_of(logic [7:0] h);
        logic [7:0] x;
        x = h;
        for (int sh = 7; sh >= 0; sh--)
        begin
            if (32'(x) >= (BUFFER_SLOTS << sh))
            begin
                x = x - 8'(BUFFER_SLOTS << sh);
            end
        end
        return x;
    endfunction

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.kind;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {1'b0, m_res_reg.msg_end, m_res_reg.msg_start, m_res_reg.length,
                       m_res_reg.handle, m_res_reg.id, m_res_reg.status};

    always_comb
    begin
        result_t r;
        logic [RES_CNT_W-1:0] need;
        r = '0;
        need = '0;
        state_next      = state_reg;
        in_next         = in_reg;
        op_next         = op_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        last_id_next    = last_id_reg;
        ovf_next        = ovf_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        s_next          = s_reg;
        t_next          = t_reg;
        pos_next        = pos_reg;
        lastidx_next    = lastidx_reg;
        expect_next     = expect_reg;
        cand_next       = cand_reg;
        n_next          = n_reg;
        any_next        = any_reg;
        status_next     = status_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        m_res_next      = m_res_reg;
        m_last_next     = m_last_reg;
        m_valid_next    = m_tready ? 1'b0 : m_valid_reg;
        raddr           = phys(i_reg);
        waddr           = phys(j_reg);
        wdata           = rdata_reg;
        wen             = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next        = s_tuser;
                    in_next.id     = s_tdata[15:0];
                    in_next.kind   = s_tdata[17:16];
                    in_next.handle = slot_of(s_tdata[25:18]);
                    in_next.length = (32'(s_tdata[36:26]) > MAX_FRAGMENT_BYTES)
                                   ? 11'(MAX_FRAGMENT_BYTES) : s_tdata[36:26];
                    state_next     = (s_tuser == OP_PROCESS) ? P_START : A_START;
                end
            end
            A_START:
            begin
                raddr = phys(CW'(count_reg - 1'b1));
                if (!seq_newer(in_reg.id, last_id_reg))
                begin
                    status_next = ST_STALE;
                    state_next  = A_RESULT;
                end
                else if (count_reg == '0)
                begin
                    pos_next   = '0;
                    state_next = A_FULLCHK;
                end
                else
                begin
                    state_next = A_LASTCHK;
                end
            end
            A_LASTCHK:
            begin
                raddr = phys('0);
                if (seq_newer(in_reg.id, rdata_reg.id))
                begin
                    pos_next   = count_reg;
                    state_next = A_FULLCHK;
                end
                else
                begin
                    i_next     = '0;
                    state_next = A_SCAN;
                end
            end
            A_SCAN:
            begin
                raddr = phys(CW'(i_reg + 1'b1));
                if (rdata_reg.id == in_reg.id)
                begin
                    status_next = ST_DUPLICATE;
                    state_next  = A_RESULT;
                end
                else if (seq_newer(rdata_reg.id, in_reg.id))
                begin
                    pos_next   = i_reg;
                    state_next = A_FULLCHK;
                end
                else if (CW'(i_reg + 1'b1) >= count_reg)
                begin
                    pos_next   = count_reg;
                    state_next = A_FULLCHK;
                end
                else
                begin
                    i_next = CW'(i_reg + 1'b1);
                end
            end
            A_FULLCHK:
            begin
                raddr = phys(CW'(count_reg - 1'b1));
                if (32'(count_reg) >= QUEUE_DEPTH)
                begin
                    ovf_next    = 1'b1;
                    status_next = ST_FULL;
                    state_next  = A_RESULT;
                end
                else if (pos_reg == count_reg)
                begin
                    state_next = A_INSERT;
                end
                else
                begin
                    j_next     = count_reg;
                    state_next = A_SHIFT;
                end
            end
            A_SHIFT:
            begin
                wen   = 1'b1;
                waddr = phys(j_reg);
                raddr = phys(CW'(j_reg - 2'd2));
                if (CW'(j_reg - 1'b1) == pos_reg)
                begin
                    state_next = A_INSERT;
                end
                else
                begin
                    j_next = CW'(j_reg - 1'b1);
                end
            end
            A_INSERT:
            begin
                wen         = 1'b1;
                waddr       = phys(pos_reg);
                wdata       = in_reg;
                count_next  = CW'(count_reg + 1'b1);
                status_next = ST_ACCEPTED;
                state_next  = A_RESULT;
            end
            A_RESULT:
            begin
                if (out_free)
                begin
                    r.kind       = RK_STATUS;
                    r.status     = status_reg;
                    m_res_next   = r;
                    m_last_next  = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            P_START:
            begin
                if (ovf_reg)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
                i_next          = '0;
                n_next          = '0;
                any_next        = 1'b0;
                hold_valid_next = 1'b0;
                state_next      = P_NEXT;
            end
            P_NEXT:
            begin
                raddr      = phys(i_reg);
                state_next = (i_reg >= count_reg) ? P_FINISH : P_HEAD;
            end
            P_HEAD:
            begin
                raddr = phys(i_reg);
                case (rdata_reg.kind)
                    FK_FULL:
                    begin
                        if (32'(n_reg) >= RESULT_CAP)
                        begin
                            state_next = P_FINISH;
                        end
                        else
                        begin
                            s_next     = i_reg;
                            t_next     = i_reg;
                            k_next     = i_reg;
                            state_next = P_EMIT;
                        end
                    end
                    FK_FIRST:
                    begin
                        expect_next = rdata_reg.id + 16'd1;
                        j_next      = CW'(i_reg + 1'b1);
                        raddr       = phys(CW'(i_reg + 1'b1));
                        if (CW'(i_reg + 1'b1) >= count_reg)
                        begin
                            i_next     = CW'(i_reg + 1'b1);
                            state_next = P_NEXT;
                        end
                        else
                        begin
                            state_next = P_RUN;
                        end
                    end
                    default:
                    begin
                        i_next     = CW'(i_reg + 1'b1);
                        state_next = P_NEXT;
                    end
                endcase
            end
            P_RUN:
            begin
                raddr = phys(CW'(j_reg + 1'b1));
                need  = n_reg + RES_CNT_W'(j_reg - i_reg) + 1'b1;
                if (rdata_reg.id != expect_reg)
                begin
                    i_next     = j_reg;
                    state_next = P_NEXT;
                end
                else if (rdata_reg.kind == FK_LAST)
                begin
                    if (32'(need) > RESULT_CAP)
                    begin
                        state_next = P_FINISH;
                    end
                    else
                    begin
                        s_next     = i_reg;
                        t_next     = j_reg;
                        k_next     = i_reg;
                        state_next = P_EMIT_RD;
                    end
                end
                else if (rdata_reg.kind != FK_MIDDLE)
                begin
                    i_next     = j_reg;
                    state_next = P_NEXT;
                end
                else if (CW'(j_reg + 1'b1) >= count_reg)
                begin
                    i_next     = CW'(j_reg + 1'b1);
                    state_next = P_NEXT;
                end
                else
                begin
                    j_next      = CW'(j_reg + 1'b1);
                    expect_next = expect_reg + 16'd1;
                end
            end
            P_EMIT_RD:
            begin
                raddr      = phys(k_reg);
                state_next = P_EMIT;
            end
            P_EMIT:
            begin
                raddr = phys(k_reg);
                if (!hold_valid_reg || out_free)
                begin
                    if (hold_valid_reg)
                    begin
                        m_res_next   = hold_reg;
                        m_last_next  = 1'b0;
                        m_valid_next = 1'b1;
                    end
                    r.kind          = RK_PACKET;
                    r.id            = rdata_reg.id;
                    r.handle        = rdata_reg.handle;
                    r.length        = rdata_reg.length;
                    r.msg_start     = (k_reg == s_reg);
                    r.msg_end       = (k_reg == t_reg);
                    hold_next       = r;
                    hold_valid_next = 1'b1;
                    n_next          = n_reg + 1'b1;
                    lastidx_next    = k_reg;
                    cand_next       = rdata_reg.id;
                    any_next        = 1'b1;
                    if (k_reg == t_reg)
                    begin
                        i_next     = CW'(t_reg + 1'b1);
                        state_next = P_NEXT;
                    end
                    else
                    begin
                        k_next = CW'(k_reg + 1'b1);
                        raddr  = phys(CW'(k_reg + 1'b1));
                    end
                end
            end
            P_FINISH:
            begin
                if (out_free)
                begin
                    if (any_reg)
                    begin
                        m_res_next      = hold_reg;
                        last_id_next    = cand_reg;
                        head_next       = head_reg + AW'(lastidx_reg + 1'b1);
                        count_next      = CW'(count_reg - lastidx_reg - 1'b1);
                        hold_valid_next = 1'b0;
                    end
                    else
                    begin
                        r.kind     = RK_NONE;
                        m_res_next = r;
                    end
                    m_last_next  = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            head_reg       <= '0;
            last_id_reg    <= 16'hFFFF;
            ovf_reg        <= 1'b0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            any_reg        <= 1'b0;
            n_reg          <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            head_reg       <= head_next;
            last_id_reg    <= last_id_next;
            ovf_reg        <= ovf_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
            any_reg        <= any_next;
            n_reg          <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg      <= in_next;
        op_reg      <= op_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        k_reg       <= k_next;
        s_reg       <= s_next;
        t_reg       <= t_next;
        pos_reg     <= pos_next;
        lastidx_reg <= lastidx_next;
        expect_reg  <= expect_next;
        cand_reg    <= cand_next;
        status_reg  <= status_next;
        hold_reg    <= hold_next;
        m_res_reg   <= m_res_next;
        m_last_reg  <= m_last_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= QUEUE_DEPTH)
        else $error("queue count above depth");

    a_result_cap: assert property (@(posedge clk) disable iff (!rst_n)
        32'(n_reg) <= RESULT_CAP)
        else $error("result count above cap");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == P_START) |=> !ovf_reg)
        else $error("overflow flag survived process start");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        wen |-> (op_reg == OP_ARRIVE && (state_reg == A_SHIFT || state_reg == A_INSERT)))
        else $error("memory written outside insert");

    a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !hold_valid_reg)
        else $error("pending result left at idle");

endmodule
